// ===== rtl/gmp_pkg.sv =====
// Shared widths, types and the step-cost function for the grid path-cost block.
`default_nettype none

package gmp_pkg;

  localparam int unsigned MaxCols  = 64;
  localparam int unsigned MaxRows  = 64;
  localparam int unsigned HeightW  = 16;
  localparam int unsigned CostW    = 24;
  localparam int unsigned DimW     = 7;
  localparam int unsigned ColW     = $clog2(MaxCols);
  localparam int unsigned RowW     = $clog2(MaxRows);

  localparam logic [CostW-1:0] CostMax = {CostW{1'b1}};

  // Configuration register indexes
  localparam logic CfgRows = 1'b0;
  localparam logic CfgCols = 1'b1;

  typedef struct packed {
    logic [HeightW-1:0] height;
    logic [CostW-1:0]   cost;
  } row_entry_t;

  typedef struct packed {
    logic first_row;
    logic first_col;
  } cell_pos_t;

  // Neighbor cost plus absolute height difference, saturated
  function automatic logic [CostW-1:0] step_cost(input row_entry_t nb,
                                                 input logic [HeightW-1:0] h);
    logic [HeightW-1:0] diff;
    logic [CostW:0]     sum;
    diff = (nb.height > h) ? (nb.height - h) : (h - nb.height);
    sum  = {1'b0, nb.cost} + {{(CostW + 1 - HeightW){1'b0}}, diff};
    return sum[CostW] ? CostMax : sum[CostW-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/gmp_row_ram.sv =====
// Previous-row store: heights and costs, one write and one registered read per cycle.
`default_nettype none

module gmp_row_ram
  import gmp_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [ColW-1:0]  waddr_i,
  input  wire row_entry_t       wdata_i,
  input  wire logic             re_i,
  input  wire logic [ColW-1:0]  raddr_i,
  output row_entry_t            rdata_o
);

  row_entry_t mem_q [MaxCols];
  row_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      // pass a same-cycle write straight through to the reader
      if (we_i && (waddr_i == raddr_i)) begin
        rdata_q <= wdata_i;
      end else begin
        rdata_q <= mem_q[raddr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/gmp_cell_cost.sv =====
// Cost of one cell from its left, upper and upper-left neighbors.
`default_nettype none

module gmp_cell_cost
  import gmp_pkg::*;
(
  input  wire cell_pos_t          pos_i,
  input  wire logic [HeightW-1:0] height_i,
  input  wire row_entry_t         left_i,
  input  wire row_entry_t         up_i,
  input  wire row_entry_t         diag_i,
  output logic [CostW-1:0]        cost_o
);

  logic [CostW-1:0] left_cost;
  logic [CostW-1:0] up_cost;
  logic [CostW-1:0] diag_cost;
  logic [CostW-1:0] min_lu;

  assign left_cost = step_cost(left_i, height_i);
  assign up_cost   = step_cost(up_i, height_i);
  assign diag_cost = step_cost(diag_i, height_i);
  assign min_lu    = (left_cost < up_cost) ? left_cost : up_cost;

  always_comb begin
    if (pos_i.first_row && pos_i.first_col) begin
      cost_o = '0;
    end else if (pos_i.first_row) begin
      cost_o = left_cost;
    end else if (pos_i.first_col) begin
      cost_o = up_cost;
    end else begin
      cost_o = (diag_cost < min_lu) ? diag_cost : min_lu;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/grid_min_path_cost_dp.sv =====
// Top level: streamed grid minimum-path cost, one cell in and one cost out.
//
// Channel   Dir  Signals                      Contents
// s_axis    in   tvalid/tready/tdata[15:0]    height
// m_axis    out  tvalid/tready/tdata[23:0]    cell_cost; tlast = grid_done
// cfg       in   cfg_we_i/cfg_idx_i/cfg_data_i  0: rows_in_use, 1: cols_in_use
//
// One cell per cycle unless m_axis stalls; results pass stage A and the output register.
// The rate is set by the left-cost loop: abs, add, saturate and three-way min are combinational.
// Previous-row RAM is read on input acceptance and written when the cell leaves stage A.
// Reset clears counters, neighbor registers and valids; row RAM is not cleared.
// A stalled output holds both full stages; input is taken when stage A is empty or moving.
`default_nettype none

module grid_min_path_cost_dp
  import gmp_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_axis_tvalid_i,
  output logic                    s_axis_tready_o,
  input  wire logic [HeightW-1:0] s_axis_tdata_i,   // [15:0] height
  output logic                    m_axis_tvalid_o,
  input  wire logic               m_axis_tready_i,
  output logic [CostW-1:0]        m_axis_tdata_o,   // [23:0] cell_cost
  output logic                    m_axis_tlast_o,   // grid_done
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_idx_i,
  input  wire logic [DimW-1:0]    cfg_data_i
);

  logic [DimW-1:0] rows_q, cols_q;
  logic [RowW-1:0] rows_m1;
  logic [ColW-1:0] cols_m1;
  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  logic            last_col, last_row;

  logic               a_valid_q;
  logic [HeightW-1:0] a_height_q;
  logic [ColW-1:0]    a_col_q;
  cell_pos_t          a_pos_q;
  logic               a_done_q;

  logic               out_valid_q;
  logic [CostW-1:0]   out_cost_q;
  logic               out_done_q;

  row_entry_t left_q, diag_q, up_entry, wr_entry;
  logic [CostW-1:0] cell_cost;
  logic             advance, in_accept, a_move;

  // Dimension clamp: zero acts as one, above max saturates
  always_comb begin
    if (rows_q == '0) begin
      rows_m1 = '0;
    end else if (rows_q > DimW'(MaxRows)) begin
      rows_m1 = RowW'(MaxRows - 1);
    end else begin
      rows_m1 = RowW'(rows_q - DimW'(1));
    end
    if (cols_q == '0) begin
      cols_m1 = '0;
    end else if (cols_q > DimW'(MaxCols)) begin
      cols_m1 = ColW'(MaxCols - 1);
    end else begin
      cols_m1 = ColW'(cols_q - DimW'(1));
    end
  end

  assign last_col = (col_q >= cols_m1);
  assign last_row = (row_q >= rows_m1);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (last_col) begin
      col_d = '0;
      row_d = last_row ? '0 : row_q + RowW'(1);
    end else begin
      col_d = col_q + ColW'(1);
    end
  end

  assign advance         = !out_valid_q || m_axis_tready_i;
  assign a_move          = a_valid_q && advance;
  assign s_axis_tready_o = !a_valid_q || advance;
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;

  assign wr_entry.height = a_height_q;
  assign wr_entry.cost   = cell_cost;

  gmp_row_ram u_row_ram (
    .clk_i   (clk_i),
    .we_i    (a_move),
    .waddr_i (a_col_q),
    .wdata_i (wr_entry),
    .re_i    (in_accept),
    .raddr_i (col_q),
    .rdata_o (up_entry)
  );

  gmp_cell_cost u_cell_cost (
    .pos_i    (a_pos_q),
    .height_i (a_height_q),
    .left_i   (left_q),
    .up_i     (up_entry),
    .diag_i   (diag_q),
    .cost_o   (cell_cost)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q      <= DimW'(4);
      cols_q      <= DimW'(4);
      col_q       <= '0;
      row_q       <= '0;
      a_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      left_q      <= '0;
      diag_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgRows: rows_q <= cfg_data_i;
          CfgCols: cols_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_accept) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      if (advance) begin
        a_valid_q   <= in_accept;
        out_valid_q <= a_valid_q;
      end else if (in_accept) begin
        a_valid_q <= 1'b1;
      end
      // upper cell of this column becomes the upper-left of the next
      if (a_move) begin
        left_q <= wr_entry;
        diag_q <= up_entry;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      a_height_q          <= s_axis_tdata_i;
      a_col_q             <= col_q;
      a_pos_q.first_row   <= (row_q == '0);
      a_pos_q.first_col   <= (col_q == '0);
      a_done_q            <= last_col && last_row;
    end
    if (a_move) begin
      out_cost_q <= cell_cost;
      out_done_q <= a_done_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_cost_q;
  assign m_axis_tlast_o  = out_done_q;

  a_frame_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && last_col && last_row |=> col_q == '0 && row_q == '0)
    else $error("counters did not wrap after the last cell");

  a_origin_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_move && a_pos_q.first_row && a_pos_q.first_col |=> m_axis_tdata_o == '0)
    else $error("first cell of a frame has nonzero cost");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> a_valid_q && out_valid_q)
    else $error("input stalled while a stage is free");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready_i |=> out_valid_q && $stable(out_cost_q))
    else $error("pending result changed under stall");

endmodule

`default_nettype wire
